// ===== src/o2p_pkg.sv =====
// ----------------------------------------------------------------------------
// o2p_pkg
// Shared types and constants for the OBD-II speed / rpm poller.
// ----------------------------------------------------------------------------
package o2p_pkg;

    localparam int TIME_WIDTH = 32;

    typedef logic [TIME_WIDTH-1:0] time_t;

    // operation codes of an input word
    typedef enum logic [1:0]
    {
        OP_TICK    = 2'd0,
        OP_FRAME   = 2'd1,
        OP_OUTCOME = 2'd2
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0]
    {
        REG_REQUEST_INTERVAL = 2'd0,
        REG_SILENCE_TIMEOUT  = 2'd1,
        REG_SWITCH_HOLDOFF   = 2'd2,
        REG_FAILURE_LIMIT    = 2'd3
    } cfg_index_t;

    localparam logic [15:0] RST_REQUEST_INTERVAL = 16'd50;
    localparam logic [15:0] RST_SILENCE_TIMEOUT  = 16'd1000;
    localparam logic [15:0] RST_SWITCH_HOLDOFF   = 16'd3000;
    localparam logic [7:0]  RST_FAILURE_LIMIT    = 8'd3;

    localparam logic [28:0] STD_REQUEST_ID = 29'h0000_07DF;
    localparam logic [28:0] EXT_REQUEST_ID = 29'h18DB_33F1;
    localparam logic [10:0] STD_REPLY_ID   = 11'h7E8;
    localparam logic [10:0] STD_REPLY_MASK = 11'h7F8;
    localparam logic [28:0] EXT_REPLY_ID   = 29'h18DA_F100;
    localparam logic [28:0] EXT_REPLY_MASK = 29'h1FFF_FF00;
    localparam logic [7:0]  SERVICE_REPLY  = 8'h41;
    localparam logic [7:0]  PID_SPEED      = 8'h0D;
    localparam logic [7:0]  PID_RPM        = 8'h0C;
    localparam logic [7:0]  FAILURES_MAX   = 8'hFF;

    typedef struct packed
    {
        logic [15:0] request_interval;
        logic [15:0] silence_timeout;
        logic [15:0] switch_holdoff;
        logic [7:0]  failure_limit;
    } cfg_t;

    typedef struct packed
    {
        logic [1:0]  operation;
        logic        send_failed;
        logic [28:0] frame_id;
        logic        frame_is_extended;
        logic [7:0]  service_byte;
        logic [7:0]  pid_byte;
        logic [7:0]  value_a;
        logic [7:0]  value_b;
    } in_item_t;

    typedef struct packed
    {
        logic        request_valid;
        logic        request_extended;
        logic [28:0] request_id;
        logic [7:0]  request_pid;
        logic [7:0]  speed_kmh;
        logic [13:0] engine_speed;
        logic        link_up;
        logic        mode_extended;
    } out_item_t;

endpackage

// ===== src/o2p_cfg.sv =====
// ----------------------------------------------------------------------------
// o2p_cfg
// Configuration register file: interval, timeout, holdoff and failure limit.
// ----------------------------------------------------------------------------
module o2p_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output o2p_pkg::cfg_t      cfg
);

    o2p_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.request_interval <= o2p_pkg::RST_REQUEST_INTERVAL;
            cfg_reg.silence_timeout  <= o2p_pkg::RST_SILENCE_TIMEOUT;
            cfg_reg.switch_holdoff   <= o2p_pkg::RST_SWITCH_HOLDOFF;
            cfg_reg.failure_limit    <= o2p_pkg::RST_FAILURE_LIMIT;
        end
        else if (cfg_valid)
        begin
            unique case (o2p_pkg::cfg_index_t'(cfg_index))
                o2p_pkg::REG_REQUEST_INTERVAL: cfg_reg.request_interval <= cfg_data;
                o2p_pkg::REG_SILENCE_TIMEOUT:  cfg_reg.silence_timeout  <= cfg_data;
                o2p_pkg::REG_SWITCH_HOLDOFF:   cfg_reg.switch_holdoff   <= cfg_data;
                o2p_pkg::REG_FAILURE_LIMIT:    cfg_reg.failure_limit    <= cfg_data[7:0];
                default:                       cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/o2p_core.sv =====
// ----------------------------------------------------------------------------
// o2p_core
// Poller state and its update for one word: timing, link tracking, values.
// ----------------------------------------------------------------------------
module o2p_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  o2p_pkg::cfg_t         cfg,
    input  logic                  step,
    input  o2p_pkg::in_item_t     item,
    output o2p_pkg::out_item_t    result
);

    o2p_pkg::time_t now_reg,        now_next;
    o2p_pkg::time_t now_inc_reg,    now_inc_next;
    o2p_pkg::time_t last_req_reg,   last_req_next;
    o2p_pkg::time_t last_reply_reg, last_reply_next;
    o2p_pkg::time_t last_switch_reg, last_switch_next;
    logic [7:0]     fail_reg,  fail_next;
    logic           ask_rpm_reg, ask_rpm_next;
    logic           link_reg,  link_next;
    logic           ext_mode_reg, ext_mode_next;
    logic [7:0]     speed_reg, speed_next;
    logic [13:0]    rpm_reg,   rpm_next;

    o2p_pkg::time_t since_req;
    o2p_pkg::time_t since_reply;
    o2p_pkg::time_t since_switch;
    logic           req_due;
    logic           silent;
    logic           holdoff_done;
    logic           frame_hit;
    logic [7:0]     fail_inc;
    logic           is_tick;
    logic           is_frame;
    logic           req;

    // now_inc_reg holds now + 1, so a tick sees the advanced time at once
    assign since_req    = now_inc_reg - last_req_reg;
    assign since_reply  = now_inc_reg - last_reply_reg;
    assign since_switch = now_reg - last_switch_reg;

    assign req_due      = since_req >= o2p_pkg::TIME_WIDTH'(cfg.request_interval);
    assign silent       = since_reply > o2p_pkg::TIME_WIDTH'(cfg.silence_timeout);
    assign holdoff_done = since_switch >= o2p_pkg::TIME_WIDTH'(cfg.switch_holdoff);

    always_comb
    begin
        if (ext_mode_reg)
        begin
            frame_hit = item.frame_is_extended
                && ((item.frame_id & o2p_pkg::EXT_REPLY_MASK) == o2p_pkg::EXT_REPLY_ID);
        end
        else
        begin
            frame_hit = !item.frame_is_extended
                && ((item.frame_id[10:0] & o2p_pkg::STD_REPLY_MASK) == o2p_pkg::STD_REPLY_ID);
        end
    end

    assign fail_inc = (fail_reg < o2p_pkg::FAILURES_MAX) ? fail_reg + 8'd1 : fail_reg;
    assign is_tick  = item.operation == o2p_pkg::OP_TICK;
    assign is_frame = item.operation == o2p_pkg::OP_FRAME;

    always_comb
    begin
        now_next         = now_reg;
        now_inc_next     = now_inc_reg;
        last_req_next    = last_req_reg;
        last_reply_next  = last_reply_reg;
        last_switch_next = last_switch_reg;
        fail_next        = fail_reg;
        ask_rpm_next     = ask_rpm_reg;
        link_next        = link_reg;
        ext_mode_next    = ext_mode_reg;
        speed_next       = speed_reg;
        rpm_next         = rpm_reg;
        req              = 1'b0;
        if (step)
        begin
            unique case (item.operation)
                o2p_pkg::OP_TICK:
                begin
                    now_next     = now_inc_reg;
                    now_inc_next = now_inc_reg + o2p_pkg::TIME_WIDTH'(1);
                    if (req_due)
                    begin
                        req           = 1'b1;
                        last_req_next = now_inc_reg;
                        ask_rpm_next  = !ask_rpm_reg;
                    end
                    if (link_reg && silent)
                    begin
                        link_next  = 1'b0;
                        speed_next = 8'd0;
                        rpm_next   = 14'd0;
                    end
                end
                o2p_pkg::OP_FRAME:
                begin
                    if (frame_hit)
                    begin
                        last_reply_next = now_reg;
                        link_next       = 1'b1;
                        fail_next       = 8'd0;
                        if (item.service_byte == o2p_pkg::SERVICE_REPLY)
                        begin
                            if (item.pid_byte == o2p_pkg::PID_SPEED)
                                speed_next = item.value_a;
                            else if (item.pid_byte == o2p_pkg::PID_RPM)
                                rpm_next = {item.value_a, item.value_b[7:2]};
                        end
                    end
                end
                o2p_pkg::OP_OUTCOME:
                begin
                    if (item.send_failed)
                    begin
                        fail_next = fail_inc;
                        if (fail_inc >= cfg.failure_limit)
                        begin
                            link_next = 1'b0;
                            if (holdoff_done)
                            begin
                                ext_mode_next    = !ext_mode_reg;
                                fail_next        = 8'd0;
                                last_switch_next = now_reg;
                            end
                        end
                    end
                end
                default:
                begin
                    // unknown operation: status only
                    req = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg         <= '0;
            now_inc_reg     <= o2p_pkg::TIME_WIDTH'(1);
            last_req_reg    <= '0;
            last_reply_reg  <= '0;
            last_switch_reg <= '0;
            fail_reg        <= 8'd0;
            ask_rpm_reg     <= 1'b0;
            link_reg        <= 1'b0;
            ext_mode_reg    <= 1'b0;
            speed_reg       <= 8'd0;
            rpm_reg         <= 14'd0;
        end
        else
        begin
            now_reg         <= now_next;
            now_inc_reg     <= now_inc_next;
            last_req_reg    <= last_req_next;
            last_reply_reg  <= last_reply_next;
            last_switch_reg <= last_switch_next;
            fail_reg        <= fail_next;
            ask_rpm_reg     <= ask_rpm_next;
            link_reg        <= link_next;
            ext_mode_reg    <= ext_mode_next;
            speed_reg       <= speed_next;
            rpm_reg         <= rpm_next;
        end
    end

    always_comb
    begin
        result.request_valid    = req;
        result.request_extended = req & ext_mode_reg;
        result.request_id       = !req ? 29'd0
                                : (ext_mode_reg ? o2p_pkg::EXT_REQUEST_ID
                                                : o2p_pkg::STD_REQUEST_ID);
        result.request_pid      = !req ? 8'd0
                                : (ask_rpm_reg ? o2p_pkg::PID_RPM : o2p_pkg::PID_SPEED);
        result.speed_kmh        = speed_next;
        result.engine_speed     = rpm_next;
        result.link_up          = link_next;
        result.mode_extended    = ext_mode_next;
    end

`ifndef ASSERT_OFF
    a_now_inc: assert property (@(posedge clk) disable iff (!rst_n)
        now_inc_reg == now_reg + o2p_pkg::TIME_WIDTH'(1))
        else $error("now_inc_reg out of step with now_reg");

    a_req_time: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_tick && req |=> last_req_reg == now_reg)
        else $error("request time not taken from the advanced tick count");

    a_frame_link: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_frame && frame_hit |=> link_reg && fail_reg == 8'd0)
        else $error("accepted reply did not raise the link");
`endif

endmodule

// ===== src/obd2_speed_rpm_poller.sv =====
// ----------------------------------------------------------------------------
// obd2_speed_rpm_poller
// OBD-II poller: timed speed / rpm requests, reply decoding, link and mode.
// ----------------------------------------------------------------------------
// One word is taken per clock cycle while the output is not stalled, and
// each word gives exactly one result word on the master side: the word lands
// in an input register, the poller state is updated and the result is formed
// in the same cycle, and the result is held in an output register until
// taken. A stalled output holds the input register, so once both registers
// hold a word s_tready follows m_tready in the same cycle.
// Configuration registers are written through the cfg channel, which is
// always ready; write them only while no word is in flight.
module obd2_speed_rpm_poller
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    // send_failed, frame_id, frame_is_extended, service_byte, pid_byte,
    // value_a, value_b, zero pad
    input  logic [63:0] s_tdata,
    // operation
    input  logic [1:0]  s_tuser,
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    // request_valid, request_extended, request_id, request_pid, speed_kmh,
    // engine_speed, link_up, mode_extended, zero pad
    output logic [63:0] m_tdata
);

    o2p_pkg::cfg_t      cfg;
    o2p_pkg::in_item_t  in_item;
    o2p_pkg::in_item_t  in_item_reg;
    o2p_pkg::out_item_t result;
    o2p_pkg::out_item_t out_item_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;

    assign cfg_ready = 1'b1;

    o2p_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        in_item.operation         = s_tuser;
        in_item.send_failed       = s_tdata[0];
        in_item.frame_id          = s_tdata[29:1];
        in_item.frame_is_extended = s_tdata[30];
        in_item.service_byte      = s_tdata[38:31];
        in_item.pid_byte          = s_tdata[46:39];
        in_item.value_a           = s_tdata[54:47];
        in_item.value_b           = s_tdata[62:55];
    end

    // word moves into the result register when that register is free or taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_item_reg <= in_item;
        if (advance)
            out_item_reg <= result;
    end

    o2p_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (in_item_reg),
        .result (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_item_reg.mode_extended,
                       out_item_reg.link_up,
                       out_item_reg.engine_speed,
                       out_item_reg.speed_kmh,
                       out_item_reg.request_pid,
                       out_item_reg.request_id,
                       out_item_reg.request_extended,
                       out_item_reg.request_valid};

`ifndef ASSERT_OFF
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but not ready");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending word lost during output stall");
`endif

endmodule

// ===== dv/tb_obd2_speed_rpm_poller.sv =====
// ----------------------------------------------------------------------------
// tb_obd2_speed_rpm_poller
// Self-checking bench for the OBD-II speed / rpm poller. Ticks, CAN replies
// and transmit outcomes are streamed in, bursty and under random output
// stalls. An in-bench model of the poller predicts every status word, and
// each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_obd2_speed_rpm_poller;

    timeunit 1ns;
    timeprecision 1ps;

    import o2p_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         IDLE_LIMIT  = 5000;
    localparam int         HOLD_CYCLES = 400;
    localparam int         DRAIN_WAIT  = 8;
    localparam int         RANDOM_RUN  = 215;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;

    obd2_speed_rpm_poller u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // poller model state
    cfg_t        regs = '{RST_REQUEST_INTERVAL, RST_SILENCE_TIMEOUT,
                          RST_SWITCH_HOLDOFF, RST_FAILURE_LIMIT};
    time_t       p_now         = '0;
    time_t       p_last_req    = '0;
    time_t       p_last_reply  = '0;
    time_t       p_last_switch = '0;
    logic [7:0]  p_failures    = '0;
    logic        p_ask_rpm     = 1'b0;
    logic        p_link        = 1'b0;
    logic        mode_ext      = 1'b0;
    logic [7:0]  p_speed       = '0;
    logic [13:0] p_rpm         = '0;

    out_item_t predicted_status[$];

    int errors        = 0;
    int items_sent    = 0;
    int words_checked = 0;
    int requests_seen = 0;
    int mode_switches = 0;
    int link_drops    = 0;
    int burst_left    = 0;
    int outage_left   = 0;
    bit no_gaps       = 1'b0;
    bit hold_req      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic out_item_t advance_poller(input in_item_t w);
        out_item_t   r;
        logic [15:0] ab;
        logic        passes;
        r  = '0;
        ab = {w.value_a, w.value_b};
        case (w.operation)
            OP_TICK:
            begin
                p_now = p_now + time_t'(1);
                if (time_t'(p_now - p_last_req) >= time_t'(regs.request_interval))
                begin
                    p_last_req         = p_now;
                    r.request_valid    = 1'b1;
                    r.request_extended = mode_ext;
                    r.request_id       = mode_ext ? EXT_REQUEST_ID : STD_REQUEST_ID;
                    r.request_pid      = p_ask_rpm ? PID_RPM : PID_SPEED;
                    p_ask_rpm          = ~p_ask_rpm;
                    requests_seen++;
                end
                if (p_link && time_t'(p_now - p_last_reply) > time_t'(regs.silence_timeout))
                begin
                    p_link  = 1'b0;
                    p_speed = '0;
                    p_rpm   = '0;
                    link_drops++;
                end
            end
            OP_FRAME:
            begin
                if (mode_ext)
                    passes = w.frame_is_extended &&
                             ((w.frame_id & EXT_REPLY_MASK) == EXT_REPLY_ID);
                else
                    passes = !w.frame_is_extended &&
                             ((w.frame_id[10:0] & STD_REPLY_MASK) == STD_REPLY_ID);
                if (passes)
                begin
                    p_last_reply = p_now;
                    p_link       = 1'b1;
                    p_failures   = '0;
                    if (w.service_byte == SERVICE_REPLY)
                    begin
                        if (w.pid_byte == PID_SPEED)
                            p_speed = w.value_a;
                        else if (w.pid_byte == PID_RPM)
                            p_rpm = ab[15:2];
                    end
                end
            end
            OP_OUTCOME:
            begin
                if (w.send_failed)
                begin
                    if (p_failures < FAILURES_MAX)
                        p_failures = p_failures + 8'd1;
                    if (p_failures >= regs.failure_limit)
                    begin
                        if (p_link)
                            link_drops++;
                        p_link = 1'b0;
                        if (time_t'(p_now - p_last_switch) >= time_t'(regs.switch_holdoff))
                        begin
                            mode_ext      = ~mode_ext;
                            p_failures    = '0;
                            p_last_switch = p_now;
                            mode_switches++;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.speed_kmh     = p_speed;
        r.engine_speed  = p_rpm;
        r.link_up       = p_link;
        r.mode_extended = mode_ext;
        return r;
    endfunction

    function automatic logic [63:0] pack_word(input in_item_t w);
        return {1'b0, w.value_b, w.value_a, w.pid_byte, w.service_byte,
                w.frame_is_extended, w.frame_id, w.send_failed};
    endfunction

    function automatic in_item_t mk_item(input logic [1:0] op, input logic sf,
                                         input logic [28:0] id, input logic ext,
                                         input logic [7:0] svc, input logic [7:0] pid,
                                         input logic [7:0] a, input logic [7:0] b);
        in_item_t w;
        w.operation         = op;
        w.send_failed       = sf;
        w.frame_id          = id;
        w.frame_is_extended = ext;
        w.service_byte      = svc;
        w.pid_byte          = pid;
        w.value_a           = a;
        w.value_b           = b;
        return w;
    endfunction

    function automatic cfg_t mk_cfg(input int ri, input int st, input int sh, input int fl);
        cfg_t c;
        c.request_interval = ri[15:0];
        c.silence_timeout  = st[15:0];
        c.switch_holdoff   = sh[15:0];
        c.failure_limit    = fl[7:0];
        return c;
    endfunction

    // a reply that the filter of the current mode lets through
    function automatic in_item_t reply_frame();
        in_item_t w;
        int       pick;
        w.operation         = OP_FRAME;
        w.send_failed       = 1'($urandom_range(0, 1));
        w.frame_id          = 29'($urandom);
        w.frame_is_extended = mode_ext;
        w.value_a           = 8'($urandom);
        w.value_b           = 8'($urandom);
        w.service_byte      = ($urandom_range(0, 9) < 8) ? SERVICE_REPLY : 8'($urandom);
        pick                = $urandom_range(0, 19);
        w.pid_byte          = (pick < 9) ? PID_SPEED : (pick < 18) ? PID_RPM : 8'($urandom);
        if (mode_ext)
            w.frame_id = EXT_REPLY_ID | 29'($urandom_range(0, 255));
        else
        begin
            w.frame_id[10:0] = STD_REPLY_ID | 11'($urandom_range(0, 7));
            if ($urandom_range(0, 3) != 0)
                w.frame_id[28:11] = '0;
        end
        return w;
    endfunction

    function automatic in_item_t next_poll_item();
        in_item_t w;
        int       roll;
        int       bitpos;
        roll = $urandom_range(0, 99);
        w    = mk_item(OP_TICK, 1'($urandom_range(0, 1)), 29'($urandom),
                       1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
        if (outage_left > 0)
            outage_left--;
        else if ($urandom_range(0, 59) == 0)
            outage_left = $urandom_range(20, 90);
        if (roll < 55)
            w.operation = OP_TICK;
        else if (roll < 77)
        begin
            // during an outage only noise arrives, so timeouts and switches happen
            if (outage_left == 0)
                w = reply_frame();
            w.operation = OP_FRAME;
        end
        else if (roll < 84)
        begin
            // near miss: wrong frame kind or one identifier bit off
            w = reply_frame();
            if ($urandom_range(0, 1))
                w.frame_is_extended = ~w.frame_is_extended;
            else
            begin
                bitpos = mode_ext ? $urandom_range(8, 28) : $urandom_range(3, 10);
                w.frame_id[bitpos] = ~w.frame_id[bitpos];
            end
        end
        else if (roll < 97)
        begin
            w.operation   = OP_OUTCOME;
            w.send_failed = ($urandom_range(0, 9) < 7);
        end
        else
            w.operation = OP_UNUSED;
        return w;
    endfunction

    task automatic send_word(input in_item_t w);
        logic accepted;
        if (!no_gaps && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tdata  <= pack_word(w);
        s_tuser  <= w.operation;
        s_tvalid <= 1'b1;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = s_tready;
            @(posedge clk);
        end
        predicted_status.push_back(advance_poller(w));
        items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (predicted_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        logic accepted;
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = cfg_ready;
            @(posedge clk);
        end
        case (idx)
            REG_REQUEST_INTERVAL: regs.request_interval = val;
            REG_SILENCE_TIMEOUT:  regs.silence_timeout  = val;
            REG_SWITCH_HOLDOFF:   regs.switch_holdoff   = val;
            REG_FAILURE_LIMIT:    regs.failure_limit    = val[7:0];
            default: ;
        endcase
    endtask

    // only called with nothing in flight
    task automatic set_config(input cfg_t c);
        write_reg(REG_REQUEST_INTERVAL, c.request_interval);
        write_reg(REG_SILENCE_TIMEOUT, c.silence_timeout);
        write_reg(REG_SWITCH_HOLDOFF, c.switch_holdoff);
        write_reg(REG_FAILURE_LIMIT, {8'h00, c.failure_limit});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        // reset settings first: no request this early
        send_word(mk_item(OP_TICK, 1'b0, '0, 1'b0, '0, '0, '0, '0));
        send_word(mk_item(OP_TICK, 1'b1, '1, 1'b1, '1, '1, '1, '1));
        wait_drained();
        set_config(mk_cfg(2, 5, 1, 2));
        send_word(mk_item(OP_TICK, 1'b0, '0, 1'b0, '0, '0, '0, '0));
        send_word(mk_item(OP_TICK, 1'b0, '0, 1'b0, '0, '0, '0, '0));
        send_word(mk_item(OP_TICK, 1'b0, '0, 1'b0, '0, '0, '0, '0));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h7E8, 1'b0, SERVICE_REPLY, PID_SPEED, 8'hFF, 8'h00));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h7EF, 1'b0, SERVICE_REPLY, PID_RPM, 8'hFF, 8'hFF));
        // upper identifier bits are ignored in standard mode
        send_word(mk_item(OP_FRAME, 1'b1, 29'h1FFF_F7E8, 1'b0, SERVICE_REPLY, PID_SPEED,
                          8'h00, 8'hFF));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h7E8, 1'b1, SERVICE_REPLY, PID_SPEED, 8'h11, 8'h00));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h7F0, 1'b0, SERVICE_REPLY, PID_SPEED, 8'h22, 8'h00));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h7E8, 1'b0, 8'h42, PID_SPEED, 8'h55, 8'h00));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h7E8, 1'b0, SERVICE_REPLY, 8'h05, 8'h66, 8'h77));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h7E9, 1'b0, SERVICE_REPLY, PID_RPM, 8'h00, 8'h03));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h7EA, 1'b0, SERVICE_REPLY, PID_RPM, 8'h12, 8'h34));
        send_word(mk_item(OP_UNUSED, 1'b1, '1, 1'b1, '1, '1, '1, '1));
        send_word(mk_item(OP_OUTCOME, 1'b0, '0, 1'b0, '0, '0, '0, '0));
        // two refusals reach the limit, holdoff has passed: switch to 29-bit
        send_word(mk_item(OP_OUTCOME, 1'b1, '0, 1'b0, '0, '0, '0, '0));
        send_word(mk_item(OP_OUTCOME, 1'b1, '0, 1'b0, '0, '0, '0, '0));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h18DA_F1FF, 1'b1, SERVICE_REPLY, PID_SPEED,
                          8'h64, 8'h00));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h18DA_F1F1, 1'b0, SERVICE_REPLY, PID_SPEED,
                          8'h01, 8'h00));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h18DA_F000, 1'b1, SERVICE_REPLY, PID_SPEED,
                          8'h02, 8'h00));
        send_word(mk_item(OP_FRAME, 1'b0, 29'h7E8, 1'b0, SERVICE_REPLY, PID_SPEED, 8'h03, 8'h00));
        // silence drops the link and clears the values
        repeat (7) send_word(mk_item(OP_TICK, 1'b0, '0, 1'b0, '0, '0, '0, '0));
        wait_drained();
    endtask

    task automatic test_failure_saturation();
        int n;
        set_config(mk_cfg(3, 65535, 65535, 255));
        send_word(reply_frame());
        for (n = 0; n < 300; n++)
        begin
            if (n % 16 == 15)
                send_word(mk_item(OP_TICK, 1'b1, 29'($urandom), 1'b0, '0, '0, '0, '0));
            else
                send_word(mk_item(OP_OUTCOME, 1'b1, 29'($urandom),
                                  1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom),
                                  8'($urandom), 8'($urandom)));
        end
        send_word(reply_frame());
        wait_drained();
    endtask

    task automatic test_random_polling(input cfg_t c, input int count);
        int n;
        set_config(c);
        outage_left = 0;
        for (n = 0; n < count; n++)
            send_word(next_poll_item());
        wait_drained();
    endtask

    task automatic test_backpressure();
        int n;
        set_config(mk_cfg($urandom_range(1, 6), $urandom_range(5, 40),
                          $urandom_range(1, 100), $urandom_range(1, 4)));
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        for (n = 0; n < 120; n++)
            send_word(next_poll_item());
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // output side: random stall patterns, or a long hold when asked
    initial
    begin
        int mode;
        int run_left;
        int hold_cnt;
        mode     = 0;
        run_left = 0;
        hold_cnt = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                hold_cnt++;
                if (hold_cnt == HOLD_CYCLES)
                begin
                    hold_req = 1'b0;
                    hold_cnt = 0;
                end
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    run_left = $urandom_range(1, 60);
                end
                run_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            @(posedge clk);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endtask

    // a result word is taken at the rising edge after this sample
    always @(negedge clk)
    begin
        out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_status.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual 0x%016h",
                         $time, m_tdata);
            end
            else
            begin
                want = predicted_status.pop_front();
                words_checked++;
                check_field("request_valid", 32'(want.request_valid), 32'(m_tdata[0]));
                check_field("request_extended", 32'(want.request_extended), 32'(m_tdata[1]));
                check_field("request_id", 32'(want.request_id), 32'(m_tdata[30:2]));
                check_field("request_pid", 32'(want.request_pid), 32'(m_tdata[38:31]));
                check_field("speed_kmh", 32'(want.speed_kmh), 32'(m_tdata[46:39]));
                check_field("engine_speed", 32'(want.engine_speed), 32'(m_tdata[60:47]));
                check_field("link_up", 32'(want.link_up), 32'(m_tdata[61]));
                check_field("mode_extended", 32'(want.mode_extended), 32'(m_tdata[62]));
                check_field("pad", 32'd0, 32'(m_tdata[63]));
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("** obd2_speed_rpm_poller: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_failure_saturation();
        test_random_polling(mk_cfg(1, 1, 1, 1), RANDOM_RUN);
        test_random_polling(mk_cfg(0, 0, 0, 0), RANDOM_RUN);
        test_random_polling(mk_cfg($urandom_range(1, 12), $urandom_range(2, 40),
                                   $urandom_range(1, 150), $urandom_range(1, 5)), RANDOM_RUN);
        test_backpressure();
        test_random_polling(mk_cfg($urandom_range(1, 12), $urandom_range(2, 40),
                                   $urandom_range(1, 150), $urandom_range(1, 5)), RANDOM_RUN);
        test_random_polling(mk_cfg(65535, 65535, 65535, 255), RANDOM_RUN);
        test_random_polling(mk_cfg($urandom_range(1, 300), $urandom_range(1, 500),
                                   $urandom_range(1, 2000), $urandom_range(1, 255)),
                            RANDOM_RUN);

        wait_drained();
        if (predicted_status.size() != 0)
        begin
            errors++;
            $display("%0t: %0d result words never arrived", $time, predicted_status.size());
        end
        $display("run: %0d words in, %0d results checked, %0d requests predicted",
                 items_sent, words_checked, requests_seen);
        $display("run: %0d link drops and %0d addressing switches, %0d errors",
                 link_drops, mode_switches, errors);
        if (errors == 0)
            $display("** obd2_speed_rpm_poller: PASSED **");
        else
            $display("** obd2_speed_rpm_poller: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/o2p_pkg.sv
src/o2p_cfg.sv
src/o2p_core.sv
src/obd2_speed_rpm_poller.sv
dv/tb_obd2_speed_rpm_poller.sv
